// File: design/tti_pkg.sv
// Shared types and constants for the timed trajectory interpolator.
package tti_pkg;

   localparam int ALPHA_BITS = 24;
   localparam int NUM_COMP   = 9;
   localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] ONE_SECOND = 48'sd65536;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_EVAL  = 2'd1,
      OP_CHECK = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      STS_OK       = 3'd0,
      STS_MODE     = 3'd1,
      STS_FEW      = 3'd2,
      STS_STALE    = 3'd3,
      STS_INVALID  = 3'd4,
      STS_LOADED   = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      CSR_SAMPLE_COUNT  = 3'd0,
      CSR_GUIDANCE_MODE = 3'd1,
      CSR_GENERATED_AT  = 3'd2,
      CSR_VALID_UNTIL   = 3'd3,
      CSR_INTENT_ID     = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISP,
      S_LOAD,
      S_ECHK,
      S_ERD,
      S_ECMP,
      S_DIV,
      S_MUL,
      S_ADD,
      S_VCHK,
      S_VRD,
      S_VCMP,
      S_RSP
   } state_type;

   // one table entry: relative time and pos/vel/acc components 0..8
   typedef struct packed {
      logic signed [47:0] t;
      logic [NUM_COMP-1:0][31:0] vec;
   } entry_type;

   typedef struct packed {
      logic [1:0] op;
      logic [3:0] sidx;
      logic signed [47:0] t;
      logic [NUM_COMP-1:0][31:0] vec;
   } req_item_type;

   typedef struct packed {
      logic [2:0] status;
      logic signed [47:0] t;
      logic [NUM_COMP-1:0][31:0] vec;
   } rsp_item_type;

   typedef struct packed {
      logic       capture;
      logic       mem_wr;
      logic       rd;
      logic       idx_clr;
      logic       idx_inc;
      logic       prev_load;
      logic       div_start;
      logic       div_step;
      logic       mul;
      logic       add;
      logic       res_clear;
      status_type res_code;
      logic       res_sample;
      logic       res_time;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic mode_bad;
      logic brake;
      logic few;
      logic stale;
      logic pre_bad;
      logic n_zero;
      logic rel_le_t;
      logic idx_zero;
      logic idx_last;
      logic t0_bad;
      logic not_incr;
      logic cover_ok;
      logic div_done;
      logic comp_last;
   } stat_type;

endpackage

// File: design/tti_if.sv
// Request and response channel interfaces.
interface tti_req_if;
   logic valid;
   logic ready;
   logic [1:0] operation;
   logic [3:0] sample_index;
   logic signed [47:0] time_value;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] vel_z;
   logic signed [31:0] acc_x;
   logic signed [31:0] acc_y;
   logic signed [31:0] acc_z;

   modport source (output valid, operation, sample_index, time_value, pos_x, pos_y, pos_z,
                   vel_x, vel_y, vel_z, acc_x, acc_y, acc_z, input ready);
   modport sink (input valid, operation, sample_index, time_value, pos_x, pos_y, pos_z,
                 vel_x, vel_y, vel_z, acc_x, acc_y, acc_z, output ready);
endinterface

interface tti_rsp_if;
   logic valid;
   logic ready;
   logic [2:0] status;
   logic signed [47:0] out_time;
   logic signed [31:0] out_pos_x;
   logic signed [31:0] out_pos_y;
   logic signed [31:0] out_pos_z;
   logic signed [31:0] out_vel_x;
   logic signed [31:0] out_vel_y;
   logic signed [31:0] out_vel_z;
   logic signed [31:0] out_acc_x;
   logic signed [31:0] out_acc_y;
   logic signed [31:0] out_acc_z;

   modport source (output valid, status, out_time, out_pos_x, out_pos_y, out_pos_z,
                   out_vel_x, out_vel_y, out_vel_z, out_acc_x, out_acc_y, out_acc_z,
                   input ready);
   modport sink (input valid, status, out_time, out_pos_x, out_pos_y, out_pos_z,
                 out_vel_x, out_vel_y, out_vel_z, out_acc_x, out_acc_y, out_acc_z,
                 output ready);
endinterface

// File: design/tti_datapath.sv
// Datapath: registers, sample table, search compares, divider and interpolator.
module tti_datapath #(
   parameter int MAX_SAMPLES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [2:0]            csr_index,
   input  logic [47:0]           csr_wdata,
   input  tti_pkg::req_item_type req_item,
   input  tti_pkg::cmd_type      cmd,
   output tti_pkg::stat_type     stat,
   output tti_pkg::rsp_item_type rsp_item
);

   localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam logic [24:0] ALPHA_ONE = 25'(1) << tti_pkg::ALPHA_BITS;

   // configuration registers
   logic [4:0]         count_ff;
   logic [1:0]         mode_ff;
   logic signed [47:0] gen_ff;
   logic signed [47:0] until_ff;
   logic signed [31:0] intent_ff;

   // item registers
   logic [1:0]              op_ff;
   logic [3:0]              sidx_ff;
   logic signed [47:0]      now_ff;
   logic [8:0][31:0]        wvec_ff;
   logic signed [47:0]      rel_ff, rel_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic [CNT_W-1:0]        idx_ff;

   tti_pkg::entry_type mem [MAX_SAMPLES];
   tti_pkg::entry_type rd_ff;
   tti_pkg::entry_type prev_ff;

   // divider
   logic [49:0]  r_ff;
   logic [48:0]  den_ff;
   logic [23:0]  q_ff;
   logic [4:0]   dcnt_ff;
   logic         forced_ff;
   logic [24:0]  falpha_ff;

   // interpolator
   logic [3:0]          comp_ff;
   logic signed [58:0]  prod_ff;

   logic [2:0]         res_status_ff;
   logic signed [47:0] res_time_ff;
   logic [8:0][31:0]   res_vec_ff;

   logic signed [48:0] now_diff;
   logic signed [48:0] den_c, num_c;
   logic [49:0]        r_shift;
   logic [24:0]        alpha;
   logic signed [31:0] comp_a, comp_b;
   logic signed [32:0] delta;
   logic signed [58:0] prod_c, round_c;
   logic signed [47:0] prev_t;
   logic signed [48:0] span;

   always_comb begin
      now_diff = {req_item.t[47], req_item.t} - {gen_ff[47], gen_ff};
      if (now_diff < 0) begin
         rel_in = '0;
      end else if (now_diff > {tti_pkg::MAX48[47], tti_pkg::MAX48}) begin
         rel_in = tti_pkg::MAX48;
      end else begin
         rel_in = now_diff[47:0];
      end
      if (32'(count_ff) > 32'(MAX_SAMPLES)) begin
         n_in = CNT_W'(MAX_SAMPLES);
      end else begin
         n_in = CNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         mode_ff   <= '0;
         gen_ff    <= '0;
         until_ff  <= '0;
         intent_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            tti_pkg::CSR_SAMPLE_COUNT:  count_ff  <= csr_wdata[4:0];
            tti_pkg::CSR_GUIDANCE_MODE: mode_ff   <= csr_wdata[1:0];
            tti_pkg::CSR_GENERATED_AT:  gen_ff    <= csr_wdata;
            tti_pkg::CSR_VALID_UNTIL:   until_ff  <= csr_wdata;
            tti_pkg::CSR_INTENT_ID:     intent_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_item.op;
         sidx_ff <= req_item.sidx;
         now_ff  <= req_item.t;
         wvec_ff <= req_item.vec;
         rel_ff  <= rel_in;
         n_ff    <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + CNT_W'(1);
      end
   end

   // sample table
   always_ff @(posedge clock) begin
      if (cmd.mem_wr && (32'(sidx_ff) < 32'(MAX_SAMPLES))) begin
         mem[IDX_W'(sidx_ff)] <= '{t: now_ff, vec: wvec_ff};
      end
      if (cmd.rd) begin
         rd_ff <= mem[idx_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prev_load) begin
         prev_ff <= rd_ff;
      end
   end

   // alpha = floor(num * 2^24 / den), one quotient bit a cycle
   always_comb begin
      den_c   = {rd_ff.t[47], rd_ff.t} - {prev_ff.t[47], prev_ff.t};
      num_c   = {rel_ff[47], rel_ff} - {prev_ff.t[47], prev_ff.t};
      r_shift = {r_ff[48:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff   <= '0;
         forced_ff <= 1'b0;
      end else if (cmd.div_start) begin
         dcnt_ff <= '0;
         r_ff    <= {1'b0, num_c};
         den_ff  <= den_c;
         q_ff    <= '0;
         if (den_c <= 0) begin
            forced_ff <= 1'b1;
            falpha_ff <= ALPHA_ONE;
         end else if (num_c <= 0) begin
            forced_ff <= 1'b1;
            falpha_ff <= '0;
         end else if (num_c >= den_c) begin
            forced_ff <= 1'b1;
            falpha_ff <= ALPHA_ONE;
         end else begin
            forced_ff <= 1'b0;
         end
      end else if (cmd.div_step && !stat.div_done) begin
         dcnt_ff <= dcnt_ff + 5'd1;
         if (r_shift >= {1'b0, den_ff}) begin
            r_ff <= r_shift - {1'b0, den_ff};
            q_ff <= {q_ff[22:0], 1'b1};
         end else begin
            r_ff <= r_shift;
            q_ff <= {q_ff[22:0], 1'b0};
         end
      end
   end

   // one component per multiply/add pair
   always_comb begin
      alpha   = forced_ff ? falpha_ff : {1'b0, q_ff};
      comp_a  = prev_ff.vec[comp_ff];
      comp_b  = rd_ff.vec[comp_ff];
      delta   = {comp_b[31], comp_b} - {comp_a[31], comp_a};
      prod_c  = delta * $signed({1'b0, alpha});
      round_c = (prod_ff + (59'sd1 <<< (tti_pkg::ALPHA_BITS - 1))) >>> tti_pkg::ALPHA_BITS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         comp_ff <= '0;
      end else if (cmd.div_start) begin
         comp_ff <= '0;
      end else if (cmd.add) begin
         comp_ff <= comp_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= prod_c;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.res_clear) begin
         res_status_ff <= cmd.res_code;
         res_time_ff   <= '0;
         res_vec_ff    <= '0;
      end else if (cmd.res_sample) begin
         res_status_ff <= tti_pkg::STS_OK;
         res_time_ff   <= rd_ff.t;
         res_vec_ff    <= rd_ff.vec;
      end else begin
         if (cmd.add) begin
            res_vec_ff[comp_ff] <= comp_a + round_c[31:0];
         end
         if (cmd.res_time) begin
            res_status_ff <= tti_pkg::STS_OK;
            res_time_ff   <= rel_ff;
         end
      end
   end

   always_comb begin
      prev_t = (idx_ff == '0) ? -tti_pkg::ONE_SECOND : prev_ff.t;
      span   = {until_ff[47], until_ff} - {gen_ff[47], gen_ff};
      stat.op        = op_ff;
      stat.mode_bad  = (mode_ff != 2'd0);
      stat.brake     = (mode_ff == 2'd1);
      stat.few       = (n_ff < CNT_W'(2));
      stat.stale     = (until_ff <= gen_ff) || (now_ff > until_ff);
      stat.pre_bad   = (until_ff <= gen_ff) || (intent_ff <= 0);
      stat.n_zero    = (n_ff == '0);
      stat.rel_le_t  = (rel_ff <= rd_ff.t);
      stat.idx_zero  = (idx_ff == '0);
      stat.idx_last  = ((idx_ff + CNT_W'(1)) == n_ff);
      stat.t0_bad    = (rd_ff.t > 48'sd1) || (rd_ff.t < -48'sd1);
      stat.not_incr  = (rd_ff.t <= prev_t);
      stat.cover_ok  = (({rd_ff.t[47], rd_ff.t} + 49'sd1) >= span);
      stat.div_done  = forced_ff || (dcnt_ff == 5'(tti_pkg::ALPHA_BITS));
      stat.comp_last = (comp_ff == 4'(tti_pkg::NUM_COMP - 1));
   end

   assign rsp_item = '{status: res_status_ff, t: res_time_ff, vec: res_vec_ff};

endmodule

// File: design/tti_ctrl.sv
// Controller: sequences load, evaluate and validity check over the datapath.
module tti_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  logic              rsp_ready,
   input  tti_pkg::stat_type stat,
   output tti_pkg::cmd_type  cmd,
   output logic              req_ready,
   output logic              rsp_valid
);

   tti_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tti_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tti_pkg::S_IDLE: if (req_fire) state_in = tti_pkg::S_DISP;
         tti_pkg::S_DISP: begin
            case (stat.op)
               tti_pkg::OP_LOAD:  state_in = tti_pkg::S_LOAD;
               tti_pkg::OP_EVAL:  state_in = tti_pkg::S_ECHK;
               tti_pkg::OP_CHECK: state_in = tti_pkg::S_VCHK;
               default:           state_in = tti_pkg::S_IDLE;
            endcase
         end
         tti_pkg::S_LOAD: state_in = tti_pkg::S_RSP;
         tti_pkg::S_ECHK: begin
            if (stat.mode_bad || stat.few || stat.stale) state_in = tti_pkg::S_RSP;
            else state_in = tti_pkg::S_ERD;
         end
         tti_pkg::S_ERD: state_in = tti_pkg::S_ECMP;
         tti_pkg::S_ECMP: begin
            if (stat.rel_le_t) begin
               state_in = stat.idx_zero ? tti_pkg::S_RSP : tti_pkg::S_DIV;
            end else if (stat.idx_last) begin
               state_in = tti_pkg::S_RSP;
            end else begin
               state_in = tti_pkg::S_ERD;
            end
         end
         tti_pkg::S_DIV: if (stat.div_done) state_in = tti_pkg::S_MUL;
         tti_pkg::S_MUL: state_in = tti_pkg::S_ADD;
         tti_pkg::S_ADD: state_in = stat.comp_last ? tti_pkg::S_RSP : tti_pkg::S_MUL;
         tti_pkg::S_VCHK: begin
            if (stat.pre_bad || stat.brake || stat.few) state_in = tti_pkg::S_RSP;
            else state_in = tti_pkg::S_VRD;
         end
         tti_pkg::S_VRD: state_in = tti_pkg::S_VCMP;
         tti_pkg::S_VCMP: begin
            if ((stat.idx_zero && stat.t0_bad) || stat.not_incr || stat.idx_last) begin
               state_in = tti_pkg::S_RSP;
            end else begin
               state_in = tti_pkg::S_VRD;
            end
         end
         tti_pkg::S_RSP: if (rsp_ready) state_in = tti_pkg::S_IDLE;
         default: state_in = tti_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.res_code = tti_pkg::STS_OK;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         tti_pkg::S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_fire;
         end
         tti_pkg::S_LOAD: begin
            cmd.mem_wr    = 1'b1;
            cmd.res_clear = 1'b1;
            cmd.res_code  = tti_pkg::STS_LOADED;
         end
         tti_pkg::S_ECHK: begin
            cmd.idx_clr = 1'b1;
            if (stat.mode_bad) begin
               cmd.res_clear = 1'b1;
               cmd.res_code  = tti_pkg::STS_MODE;
            end else if (stat.few) begin
               cmd.res_clear = 1'b1;
               cmd.res_code  = tti_pkg::STS_FEW;
            end else if (stat.stale) begin
               cmd.res_clear = 1'b1;
               cmd.res_code  = tti_pkg::STS_STALE;
            end
         end
         tti_pkg::S_ERD, tti_pkg::S_VRD: cmd.rd = 1'b1;
         tti_pkg::S_ECMP: begin
            if (stat.rel_le_t) begin
               if (stat.idx_zero) cmd.res_sample = 1'b1;
               else cmd.div_start = 1'b1;
            end else begin
               cmd.prev_load = 1'b1;
               cmd.idx_inc   = 1'b1;
               // ran past the last sample: hold it
               cmd.res_sample = stat.idx_last;
            end
         end
         tti_pkg::S_DIV: cmd.div_step = 1'b1;
         tti_pkg::S_MUL: cmd.mul = 1'b1;
         tti_pkg::S_ADD: begin
            cmd.add      = 1'b1;
            cmd.res_time = stat.comp_last;
         end
         tti_pkg::S_VCHK: begin
            cmd.idx_clr = 1'b1;
            if (stat.pre_bad) begin
               cmd.res_clear = 1'b1;
               cmd.res_code  = tti_pkg::STS_INVALID;
            end else if (stat.brake) begin
               cmd.res_clear = 1'b1;
               cmd.res_code  = stat.n_zero ? tti_pkg::STS_OK : tti_pkg::STS_INVALID;
            end else if (stat.few) begin
               cmd.res_clear = 1'b1;
               cmd.res_code  = tti_pkg::STS_INVALID;
            end
         end
         tti_pkg::S_VCMP: begin
            cmd.prev_load = 1'b1;
            cmd.idx_inc   = 1'b1;
            if ((stat.idx_zero && stat.t0_bad) || stat.not_incr) begin
               cmd.res_clear = 1'b1;
               cmd.res_code  = tti_pkg::STS_INVALID;
            end else if (stat.idx_last) begin
               cmd.res_clear = 1'b1;
               cmd.res_code  = stat.cover_ok ? tti_pkg::STS_OK : tti_pkg::STS_INVALID;
            end
         end
         tti_pkg::S_RSP: rsp_valid = 1'b1;
         default: ;
      endcase
   end

endmodule

// File: design/timed_trajectory_interpolator.sv
// Timed trajectory interpolator: sample table with timed linear interpolation.
//
// Usage: words enter on req_bus (valid/ready) and one result word per
// load, evaluate or check leaves on rsp_bus; operation code 3 is dropped
// without a result. Registers are written through csr_wr_en/csr_index/
// csr_wdata only while the block is idle; the user, not the block, ensures it.
// Evaluate scans the table with one registered read per entry, up to the
// first sample at or after the requested time; between two samples it then
// runs the divider (one quotient bit per cycle) and nine multiply/add pairs.
// The validity check scans the table the same way. Load, and an evaluate or
// check that fails its first tests, go straight to the result.
// One word is in flight at a time: req ready is low from accept until the
// result word is taken. A stalled receiver holds the result register
// steady and keeps the request side closed.
// Reset clears the control state and all configuration registers to zero;
// the sample table is not cleared, so a slot must be loaded before use.
module timed_trajectory_interpolator #(
   parameter int MAX_SAMPLES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_index,
   input  logic [47:0]  csr_wdata,
   tti_req_if.sink      req_bus,
   tti_rsp_if.source    rsp_bus
);

   tti_pkg::cmd_type      cmd;
   tti_pkg::stat_type     stat;
   tti_pkg::req_item_type req_item;
   tti_pkg::rsp_item_type rsp_item;
   logic                  req_fire;

   assign req_fire = req_bus.valid && req_bus.ready;

   assign req_item.op   = req_bus.operation;
   assign req_item.sidx = req_bus.sample_index;
   assign req_item.t    = req_bus.time_value;
   assign req_item.vec  = {req_bus.acc_z, req_bus.acc_y, req_bus.acc_x,
                           req_bus.vel_z, req_bus.vel_y, req_bus.vel_x,
                           req_bus.pos_z, req_bus.pos_y, req_bus.pos_x};

   tti_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid)
   );

   tti_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_item  (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_item  (rsp_item)
   );

   assign rsp_bus.status    = rsp_item.status;
   assign rsp_bus.out_time  = rsp_item.t;
   assign rsp_bus.out_pos_x = rsp_item.vec[0];
   assign rsp_bus.out_pos_y = rsp_item.vec[1];
   assign rsp_bus.out_pos_z = rsp_item.vec[2];
   assign rsp_bus.out_vel_x = rsp_item.vec[3];
   assign rsp_bus.out_vel_y = rsp_item.vec[4];
   assign rsp_bus.out_vel_z = rsp_item.vec[5];
   assign rsp_bus.out_acc_x = rsp_item.vec[6];
   assign rsp_bus.out_acc_y = rsp_item.vec[7];
   assign rsp_bus.out_acc_z = rsp_item.vec[8];

   // one word in flight: never open for requests while a result is shown
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_bus.ready && rsp_bus.valid))
      else $error("request accepted while result pending");

   // an accepted word closes the request side on the next cycle
   a_close_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_bus.ready)
      else $error("request side stayed open after accept");

   // non-ok results carry no time; pos_x and acc_z are checked as zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.status != tti_pkg::STS_OK)) |->
      ((rsp_bus.out_time == '0) && (rsp_bus.out_pos_x == '0) && (rsp_bus.out_acc_z == '0)))
      else $error("non-ok result with payload");

endmodule
